// ===== rtl/five_bit_text_symbol_decoder_unit_macros.svh =====
// Assertion macros used by the five-bit text symbol decoder back end.
`ifndef FIVE_BIT_TEXT_SYMBOL_DECODER_UNIT_MACROS_SVH
`define FIVE_BIT_TEXT_SYMBOL_DECODER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FBTSD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FBTSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FBTSD_ASSERT(lbl, clk, rstn, prop, msg)
`define FBTSD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/fbtsd_pkg.sv =====
// Shared types, constants and the symbol expansion function of the text symbol decoder.
package fbtsd_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [4:0] SYM_LAST_LETTER = 5'd25;
    localparam logic [4:0] SYM_SPACE       = 5'd26;
    localparam logic [4:0] SYM_DOT         = 5'd27;
    localparam logic [4:0] SYM_SLASH       = 5'd28;
    localparam logic [4:0] SYM_ESC_ONE     = 5'd29;
    localparam logic [4:0] SYM_ESC_TWO     = 5'd30;
    localparam logic [4:0] SYM_END         = 5'd31;
    localparam logic [4:0] SYM_DIGIT_BASE  = 5'd24;

    localparam logic [4:0] WORD_AND  = 5'd0;
    localparam logic [4:0] WORD_BANG = 5'd1;
    localparam logic [4:0] WORD_THE  = 5'd2;
    localparam logic [4:0] WORD_YOU  = 5'd3;

    localparam logic [7:0] CHR_A     = 8'h41;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_DOT   = 8'h2E;
    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_STAR  = 8'h2A;
    localparam logic [7:0] CHR_BANG  = 8'h21;
    localparam logic [7:0] CHR_NUL   = 8'h00;

    localparam logic [3:0][7:0] STR_AND = {8'h20, 8'h44, 8'h4E, 8'h41};
    localparam logic [3:0][7:0] STR_THE = {8'h20, 8'h45, 8'h48, 8'h54};
    localparam logic [3:0][7:0] STR_YOU = {8'h20, 8'h55, 8'h4F, 8'h59};

    localparam logic [15:0] CAPACITY_RESET = 16'd200;

    typedef enum logic [1:0] {
        CFG_STOP_ON_END_CODE  = 2'd0,
        CFG_APPEND_TERMINATOR = 2'd1,
        CFG_OUT_CAPACITY      = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_ONE   = 2'd1,
        ESC_TWO   = 2'd2,
        ESC_THREE = 2'd3
    } esc_t;

    typedef struct packed {
        logic [4:0] symbol;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       last;
        logic       status;
    } out_t;

    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [2:0]      count;
        logic            stop;
        logic            eot;
    } cmd_t;

    typedef struct packed {
        logic        append_terminator;
        logic [15:0] out_capacity;
    } back_cfg_t;

    function automatic cmd_t expand(input esc_t esc, input logic [4:0] sym);
        cmd_t c;
        c = '0;
        unique case (esc)
            ESC_NONE: begin
                if (sym <= SYM_LAST_LETTER) begin
                    c.count    = 3'd1;
                    c.chars[0] = CHR_A + {3'b000, sym};
                end else begin
                    unique case (sym)
                        SYM_SPACE: begin
                            c.count    = 3'd1;
                            c.chars[0] = CHR_SPACE;
                        end
                        SYM_DOT: begin
                            c.count    = 3'd1;
                            c.chars[0] = CHR_DOT;
                        end
                        SYM_SLASH: begin
                            c.count    = 3'd1;
                            c.chars[0] = CHR_SLASH;
                        end
                        SYM_END: begin
                            c.count    = 3'd1;
                            c.chars[0] = CHR_NUL;
                        end
                        default: c.count = 3'd0;
                    endcase
                end
            end
            ESC_ONE: begin
                if (sym < SYM_DIGIT_BASE) begin
                    c.count    = 3'd2;
                    c.chars[0] = CHR_STAR;
                    c.chars[1] = CHR_A + {3'b000, sym};
                end else begin
                    c.count    = 3'd1;
                    c.chars[0] = CHR_ZERO + {3'b000, sym - SYM_DIGIT_BASE};
                end
            end
            default: begin
                unique case (sym)
                    WORD_AND: begin
                        c.count = 3'd4;
                        c.chars = STR_AND;
                    end
                    WORD_BANG: begin
                        c.count    = 3'd1;
                        c.chars[0] = CHR_BANG;
                    end
                    WORD_THE: begin
                        c.count = 3'd4;
                        c.chars = STR_THE;
                    end
                    WORD_YOU: begin
                        c.count = 3'd4;
                        c.chars = STR_YOU;
                    end
                    default: begin
                        c.count    = 3'd1;
                        c.chars[0] = CHR_SPACE;
                    end
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/fbtsd_front.sv =====
// Front end: accepts symbols, tracks the escape state and issues expansion commands.
module fbtsd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fbtsd_pkg::in_t    s_data,
    input  logic              stop_on_end_code,
    input  logic              q_ready,
    output logic              q_push,
    output fbtsd_pkg::cmd_t   q_cmd
);

    fbtsd_pkg::esc_t esc_reg, esc_next;
    logic            is_stop;

    assign s_ready = q_ready;
    assign q_push  = s_valid && q_ready;
    assign is_stop = (s_data.symbol == fbtsd_pkg::SYM_END) && stop_on_end_code;

    always_comb begin
        q_cmd      = fbtsd_pkg::expand(esc_reg, s_data.symbol);
        q_cmd.eot  = s_data.end_of_text;
        q_cmd.stop = is_stop;
        if (is_stop) begin
            q_cmd.count = 3'd0;
            q_cmd.chars = '0;
        end
    end

    always_comb begin
        esc_next = esc_reg;
        if (!is_stop) begin
            if (esc_reg == fbtsd_pkg::ESC_NONE) begin
                if (s_data.symbol == fbtsd_pkg::SYM_ESC_ONE) begin
                    esc_next = fbtsd_pkg::ESC_ONE;
                end else if (s_data.symbol == fbtsd_pkg::SYM_ESC_TWO) begin
                    esc_next = fbtsd_pkg::ESC_TWO;
                end
            end else begin
                esc_next = fbtsd_pkg::ESC_NONE;
            end
        end
        if (s_data.end_of_text) begin
            esc_next = fbtsd_pkg::ESC_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg <= fbtsd_pkg::ESC_NONE;
        end else if (q_push) begin
            esc_reg <= esc_next;
        end
    end

endmodule

// ===== rtl/fbtsd_queue.sv =====
// Small command queue between the front end and the byte emitter.
module fbtsd_queue #(
    parameter int DEPTH = fbtsd_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  fbtsd_pkg::cmd_t   push_cmd,
    output logic              push_ready,
    input  logic              pop,
    output logic              head_valid,
    output fbtsd_pkg::cmd_t   head_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fbtsd_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/fbtsd_back.sv =====
// Back end: emits one byte per cycle while the output is not stalled, counts against capacity and closes each text.
`include "five_bit_text_symbol_decoder_unit_macros.svh"
module fbtsd_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  fbtsd_pkg::back_cfg_t   cfg,
    input  logic                   head_valid,
    input  fbtsd_pkg::cmd_t        head_cmd,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output fbtsd_pkg::out_t        m_data
);

    logic            m_valid_reg;
    fbtsd_pkg::out_t m_data_reg;
    logic [2:0]      idx_reg, idx_next;
    logic [15:0]     bytes_reg, bytes_next;
    logic            discarding_reg, discarding_next;
    logic            out_free, out_load, room;
    fbtsd_pkg::out_t out_next, fin_data, ovf_data;

    assign out_free = !m_valid_reg || m_ready;
    assign room     = bytes_reg < cfg.out_capacity;
    assign ovf_data = '{out_char: 8'h00, has_char: 1'b0, last: 1'b1, status: 1'b1};

    always_comb begin
        if (!cfg.append_terminator) begin
            fin_data = '{out_char: 8'h00, has_char: 1'b0, last: 1'b1, status: 1'b0};
        end else if (room) begin
            fin_data = '{out_char: 8'h00, has_char: 1'b1, last: 1'b1, status: 1'b0};
        end else begin
            fin_data = ovf_data;
        end
    end

    always_comb begin
        out_load        = 1'b0;
        out_next        = '0;
        pop             = 1'b0;
        idx_next        = idx_reg;
        bytes_next      = bytes_reg;
        discarding_next = discarding_reg;
        if (head_valid && out_free) begin
            if (discarding_reg) begin
                pop = 1'b1;
                if (head_cmd.eot) begin
                    discarding_next = 1'b0;
                    bytes_next      = '0;
                end
            end else if (head_cmd.stop) begin
                out_load = 1'b1;
                out_next = fin_data;
                pop      = 1'b1;
                idx_next = '0;
                if (head_cmd.eot) begin
                    bytes_next = '0;
                end else begin
                    discarding_next = 1'b1;
                end
            end else if (idx_reg < head_cmd.count) begin
                out_load = 1'b1;
                if (room) begin
                    out_next.out_char = head_cmd.chars[idx_reg[1:0]];
                    out_next.has_char = 1'b1;
                    bytes_next        = bytes_reg + 16'd1;
                    if ((idx_reg + 3'd1 == head_cmd.count) && !head_cmd.eot) begin
                        pop      = 1'b1;
                        idx_next = '0;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end else begin
                    out_next = ovf_data;
                    pop      = 1'b1;
                    idx_next = '0;
                    if (head_cmd.eot) begin
                        bytes_next = '0;
                    end else begin
                        discarding_next = 1'b1;
                    end
                end
            end else begin
                pop      = 1'b1;
                idx_next = '0;
                if (head_cmd.eot) begin
                    out_load   = 1'b1;
                    out_next   = fin_data;
                    bytes_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            idx_reg        <= '0;
            bytes_reg      <= '0;
            discarding_reg <= 1'b0;
        end else begin
            if (out_free) begin
                m_valid_reg <= out_load;
            end
            idx_reg        <= idx_next;
            bytes_reg      <= bytes_next;
            discarding_reg <= discarding_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `FBTSD_ASSERT(a_ovf_is_last, aclk, aresetn, m_valid_reg && m_data_reg.status |-> m_data_reg.last && !m_data_reg.has_char, "overflow marker must be a bare last result")
    `FBTSD_ASSERT(a_bare_is_zero, aclk, aresetn, m_valid_reg && !m_data_reg.has_char |-> m_data_reg.out_char == 8'h00 && m_data_reg.last, "bare marker must be a zero last result")
    `FBTSD_ASSERT(a_discard_after_last, aclk, aresetn, $rose(discarding_reg) |-> m_valid_reg && m_data_reg.last, "discarding must follow a last result")
    `FBTSD_ASSERT(a_idx_in_range, aclk, aresetn, idx_reg <= 3'd4, "byte index beyond the longest expansion")

endmodule

// ===== rtl/five_bit_text_symbol_decoder_unit.sv =====
// The first result of a symbol passes through the command queue and the output register after acceptance.
// The emitter gives one result byte per cycle while the output is not stalled; an end of text adds
// a closing result after its bytes, and escape openers give no result.
// Input takes a new symbol every cycle while the command queue has room.
// Reset (synchronous, active low) clears escape, byte count, discarding, queue and output.
// Top level of the five-bit text symbol decoder: configuration registers and the three stages.
module five_bit_text_symbol_decoder_unit #(
    parameter int QUEUE_DEPTH = fbtsd_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fbtsd_pkg::in_t    s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output fbtsd_pkg::out_t   m_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_wdata
);

    logic                 stop_on_end_code_reg;
    logic                 append_terminator_reg;
    logic [15:0]          out_capacity_reg;
    fbtsd_pkg::back_cfg_t back_cfg;
    logic                 q_push, q_ready, q_pop, head_valid;
    fbtsd_pkg::cmd_t      push_cmd, head_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_on_end_code_reg  <= 1'b0;
            append_terminator_reg <= 1'b0;
            out_capacity_reg      <= fbtsd_pkg::CAPACITY_RESET;
        end else if (cfg_we) begin
            case (fbtsd_pkg::cfg_index_t'(cfg_index))
                fbtsd_pkg::CFG_STOP_ON_END_CODE:  stop_on_end_code_reg  <= cfg_wdata[0];
                fbtsd_pkg::CFG_APPEND_TERMINATOR: append_terminator_reg <= cfg_wdata[0];
                fbtsd_pkg::CFG_OUT_CAPACITY:      out_capacity_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign back_cfg.append_terminator = append_terminator_reg;
    assign back_cfg.out_capacity      = out_capacity_reg;

    fbtsd_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .stop_on_end_code (stop_on_end_code_reg),
        .q_ready          (q_ready),
        .q_push           (q_push),
        .q_cmd            (push_cmd)
    );

    fbtsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    fbtsd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (back_cfg),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
